// ===== rtl/core/mas_pkg.sv =====
// Shared constants, codes and result types of the macro argument splitter.
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int MAX_PARAMS   = 32;
	localparam int MAX_NEST     = 16;

	localparam int BYTES_W = $clog2(BUFFER_BYTES + 1);
	localparam int PIDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int DEPTH_W = $clog2(MAX_NEST + 1);
	localparam int NEST_IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef enum logic [1:0] {
		KIND_CHAR,
		KIND_PARAM,
		KIND_CALL,
		KIND_NOTE
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_UNBALANCED,
		ERR_NL_STRING,
		ERR_UNTERMINATED,
		ERR_OVERFLOW,
		ERR_TOO_MANY,
		ERR_NESTING,
		ERR_MISMATCH
	} err_t;

	typedef struct packed {
		logic [7:0] ch;
		kind_t      kind;
		err_t       err;
		logic [5:0] total;
		logic       newline;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0]     cnt;
		res_t [1:0]     item;
	} push_t;

endpackage

`default_nettype wire

// ===== rtl/core/mas_front.sv =====
// Scanner front end: accepts characters, tracks nesting and modes, forms results.
`timescale 1ns / 1ps
`default_nettype none

module mas_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [7:0]           in_char,
	input  wire logic                 end_of_input,
	input  wire logic [5:0]           expected_params,
	input  wire logic                 match_all,
	output mas_pkg::push_t            push
);

	typedef enum logic [2:0] {
		M_NORMAL,
		M_SLASH,
		M_COMMENT,
		M_STAR,
		M_STRING,
		M_ESCAPE
	} mode_t;

	typedef enum logic [1:0] {
		BR_PAREN,
		BR_BRACE,
		BR_SQUARE
	} bracket_t;

	typedef enum logic [2:0] {
		POST_NONE,
		POST_POP,
		POST_PUSH,
		POST_STRING,
		POST_NORMAL,
		POST_ESCAPE,
		POST_NLSTR
	} post_t;

	mode_t                      mode_q, mode_n, eff_mode;
	logic [mas_pkg::DEPTH_W-1:0] depth_q, depth_n;
	logic [mas_pkg::PIDX_W-1:0]  pidx_q, pidx_n;
	logic [mas_pkg::BYTES_W-1:0] bytes_q, bytes_n;
	logic                        qdbl_q, qdbl_n;
	logic                        fnb_q, fnb_n;
	logic [1:0]                  stack_q [mas_pkg::MAX_NEST];

	logic [mas_pkg::NEST_IW-1:0] top_idx, push_idx;
	logic [7:0]                  top_close;
	logic                        is_closer;
	logic                        is_opener;
	bracket_t                    open_kind;
	logic                        push_en;

	logic                        newline;
	logic                        end_req;
	mas_pkg::err_t               end_code;
	logic                        copy_req;
	logic [7:0]                  copy_ch;
	post_t                       post;
	logic                        note1;
	logic                        param_req;
	logic [5:0]                  total;
	mas_pkg::err_t               call_err;
	logic [7:0]                  quote_ch;
	mas_pkg::res_t [1:0]         res;
	logic [1:0]                  cnt;

	function automatic logic is_blank(input logic [7:0] c);
		return c == mas_pkg::CH_SPACE || c == mas_pkg::CH_TAB || c == mas_pkg::CH_VT ||
			c == mas_pkg::CH_FF || c == mas_pkg::CH_CR;
	endfunction

	function automatic mas_pkg::res_t make_res(input mas_pkg::kind_t kind,
		input logic [7:0] ch, input mas_pkg::err_t err, input logic [5:0] tot,
		input logic nl);
		mas_pkg::res_t r;
		r.ch      = ch;
		r.kind    = kind;
		r.err     = err;
		r.total   = tot;
		r.newline = nl;
		r.last    = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] closer_of(input logic [1:0] kind);
		logic [7:0] c;
		case (bracket_t'(kind))
			BR_BRACE:  c = mas_pkg::CH_RBRACE;
			BR_SQUARE: c = mas_pkg::CH_RSQUARE;
			default:   c = mas_pkg::CH_RPAREN;
		endcase
		return c;
	endfunction

	assign top_idx  = mas_pkg::NEST_IW'(depth_q - 1'b1);
	assign push_idx = mas_pkg::NEST_IW'(depth_q);
	assign top_close = (depth_q != '0) ? closer_of(stack_q[top_idx]) : mas_pkg::CH_RPAREN;
	assign is_closer = in_char == mas_pkg::CH_RPAREN ||
		(match_all && (in_char == mas_pkg::CH_RBRACE || in_char == mas_pkg::CH_RSQUARE));
	assign quote_ch = qdbl_q ? mas_pkg::CH_DQUOTE : mas_pkg::CH_SQUOTE;

	always_comb begin
		is_opener = 1'b1;
		open_kind = BR_PAREN;
		if (in_char == mas_pkg::CH_LPAREN) begin
			open_kind = BR_PAREN;
		end else if (match_all && in_char == mas_pkg::CH_LBRACE) begin
			open_kind = BR_BRACE;
		end else if (match_all && in_char == mas_pkg::CH_LSQUARE) begin
			open_kind = BR_SQUARE;
		end else begin
			is_opener = 1'b0;
		end
	end

	always_comb begin
		depth_n  = depth_q;
		mode_n   = mode_q;
		qdbl_n   = qdbl_q;
		pidx_n   = pidx_q;
		fnb_n    = fnb_q;
		bytes_n  = bytes_q;
		push_en  = 1'b0;
		res      = '0;
		cnt      = 2'd0;
		end_req  = 1'b0;
		end_code = mas_pkg::ERR_NONE;
		copy_req = 1'b0;
		copy_ch  = in_char;
		post     = POST_NONE;
		note1    = 1'b0;
		param_req = 1'b0;
		total    = '0;
		call_err = mas_pkg::ERR_NONE;
		newline  = !end_of_input && in_char == mas_pkg::CH_LF;
		eff_mode = mode_q;

		// A slash that did not open a comment is copied before anything else.
		if (mode_q == M_SLASH && (end_of_input || in_char != mas_pkg::CH_STAR)) begin
			eff_mode = M_NORMAL;
			mode_n   = M_NORMAL;
			if (bytes_n >= mas_pkg::BYTES_W'(mas_pkg::BUFFER_BYTES)) begin
				end_req  = 1'b1;
				end_code = mas_pkg::ERR_OVERFLOW;
			end else begin
				bytes_n = bytes_n + 1'b1;
				if (pidx_n == '0) begin
					fnb_n = 1'b1;
				end
				res[cnt[0]] = make_res(mas_pkg::KIND_CHAR, mas_pkg::CH_SLASH,
					mas_pkg::ERR_NONE, 6'd0, newline);
				cnt = cnt + 2'd1;
			end
		end

		if (!end_req) begin
			if (end_of_input) begin
				end_req  = 1'b1;
				end_code = mas_pkg::ERR_UNTERMINATED;
			end else begin
				unique case (eff_mode)
					M_SLASH: begin
						mode_n = M_COMMENT;
					end
					M_COMMENT: begin
						if (in_char == mas_pkg::CH_STAR) begin
							mode_n = M_STAR;
						end
					end
					M_STAR: begin
						if (in_char == mas_pkg::CH_SLASH) begin
							mode_n = M_NORMAL;
						end else if (in_char != mas_pkg::CH_STAR) begin
							mode_n = M_COMMENT;
						end
					end
					M_STRING: begin
						copy_req = 1'b1;
						if (in_char == quote_ch) begin
							post = POST_NORMAL;
						end else if (in_char == mas_pkg::CH_BSLASH) begin
							post = POST_ESCAPE;
						end else if (in_char == mas_pkg::CH_LF) begin
							copy_ch = quote_ch;
							post    = POST_NLSTR;
						end
					end
					M_ESCAPE: begin
						copy_req = 1'b1;
						post     = POST_STRING;
					end
					default: begin
						mode_n = M_NORMAL;
						if (in_char == top_close) begin
							if (depth_q == '0) begin
								end_req = 1'b1;
							end else begin
								copy_req = 1'b1;
								post     = POST_POP;
							end
						end else if (is_closer) begin
							note1 = 1'b1;
						end else if (is_opener) begin
							if (depth_q >= mas_pkg::DEPTH_W'(mas_pkg::MAX_NEST)) begin
								end_req  = 1'b1;
								end_code = mas_pkg::ERR_NESTING;
							end else begin
								copy_req = 1'b1;
								post     = POST_PUSH;
							end
						end else if (in_char == mas_pkg::CH_LF) begin
							copy_req = 1'b1;
							copy_ch  = mas_pkg::CH_SPACE;
						end else if (in_char == mas_pkg::CH_SLASH) begin
							mode_n = M_SLASH;
						end else if (in_char == mas_pkg::CH_COMMA) begin
							if (depth_q != '0) begin
								copy_req = 1'b1;
							end else if (6'(pidx_q) + 6'd1 >= 6'(mas_pkg::MAX_PARAMS)) begin
								end_req  = 1'b1;
								end_code = mas_pkg::ERR_TOO_MANY;
							end else begin
								param_req = 1'b1;
							end
						end else if (in_char == mas_pkg::CH_DQUOTE ||
							in_char == mas_pkg::CH_SQUOTE) begin
							copy_req = 1'b1;
							post     = POST_STRING;
						end else begin
							copy_req = 1'b1;
						end
					end
				endcase
			end
		end

		if (copy_req) begin
			if (bytes_n >= mas_pkg::BYTES_W'(mas_pkg::BUFFER_BYTES)) begin
				end_req  = 1'b1;
				end_code = mas_pkg::ERR_OVERFLOW;
			end else begin
				bytes_n = bytes_n + 1'b1;
				if (pidx_n == '0 && !is_blank(copy_ch)) begin
					fnb_n = 1'b1;
				end
				res[cnt[0]] = make_res(mas_pkg::KIND_CHAR, copy_ch,
					(post == POST_NLSTR) ? mas_pkg::ERR_NL_STRING : mas_pkg::ERR_NONE,
					6'd0, newline);
				cnt = cnt + 2'd1;
				case (post)
					POST_POP: begin
						depth_n = depth_n - 1'b1;
					end
					POST_PUSH: begin
						push_en = 1'b1;
						depth_n = depth_n + 1'b1;
					end
					POST_STRING: begin
						mode_n = M_STRING;
						if (eff_mode != M_ESCAPE) begin
							qdbl_n = in_char == mas_pkg::CH_DQUOTE;
						end
					end
					POST_NORMAL: begin
						mode_n = M_NORMAL;
					end
					POST_ESCAPE: begin
						mode_n = M_ESCAPE;
					end
					POST_NLSTR: begin
						// The broken string closes one nesting level, or the call at the top.
						mode_n = M_NORMAL;
						if (depth_n != '0) begin
							depth_n = depth_n - 1'b1;
							res[cnt[0]] = make_res(mas_pkg::KIND_NOTE, 8'd0,
								mas_pkg::ERR_UNTERMINATED, 6'd0, newline);
							cnt = cnt + 2'd1;
						end else begin
							end_req  = 1'b1;
							end_code = mas_pkg::ERR_UNTERMINATED;
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (note1) begin
			res[cnt[0]] = make_res(mas_pkg::KIND_NOTE, 8'd0, mas_pkg::ERR_UNBALANCED,
				6'd0, newline);
			cnt = cnt + 2'd1;
		end

		if (param_req) begin
			if (bytes_n >= mas_pkg::BYTES_W'(mas_pkg::BUFFER_BYTES)) begin
				end_req  = 1'b1;
				end_code = mas_pkg::ERR_OVERFLOW;
			end else begin
				bytes_n = bytes_n + 1'b1;
				pidx_n  = pidx_n + 1'b1;
				res[cnt[0]] = make_res(mas_pkg::KIND_PARAM, 8'd0, mas_pkg::ERR_NONE,
					6'd0, newline);
				cnt = cnt + 2'd1;
			end
		end

		if (end_req) begin
			total = (pidx_n == '0 && !fnb_n) ? 6'd0 : 6'(pidx_n) + 6'd1;
			call_err = end_code;
			if (end_code == mas_pkg::ERR_NONE) begin
				if (bytes_n >= mas_pkg::BYTES_W'(mas_pkg::BUFFER_BYTES)) begin
					call_err = mas_pkg::ERR_OVERFLOW;
				end else if (total != expected_params) begin
					call_err = mas_pkg::ERR_MISMATCH;
				end
			end
			res[cnt[0]] = make_res(mas_pkg::KIND_CALL, 8'd0, call_err, total, newline);
			cnt = cnt + 2'd1;
			depth_n = '0;
			mode_n  = M_NORMAL;
			qdbl_n  = 1'b0;
			pidx_n  = '0;
			fnb_n   = 1'b0;
			bytes_n = '0;
		end

		if (cnt == 2'd1) begin
			res[0].last = 1'b1;
		end else if (cnt == 2'd2) begin
			res[1].last = 1'b1;
		end
	end

	always_comb begin
		push.cnt  = accept ? cnt : 2'd0;
		push.item = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			depth_q <= '0;
			pidx_q  <= '0;
			bytes_q <= '0;
			qdbl_q  <= 1'b0;
			fnb_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_n;
			depth_q <= depth_n;
			pidx_q  <= pidx_n;
			bytes_q <= bytes_n;
			qdbl_q  <= qdbl_n;
			fnb_q   <= fnb_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && push_en) begin
			stack_q[push_idx] <= open_kind;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mas_queue.sv =====
// Result queue between the scanner and the output stage: two writes, one read.
`timescale 1ns / 1ps
`default_nettype none

module mas_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mas_pkg::push_t  push,
	input  wire logic            pop,
	output mas_pkg::res_t        head,
	output logic                 not_empty,
	output logic                 full
);

	mas_pkg::res_t                 entry_q [mas_pkg::QUEUE_DEPTH];
	logic [mas_pkg::QUEUE_AW-1:0]  wr_q, rd_q, wr_next;
	logic [mas_pkg::QUEUE_CW-1:0]  count_q;

	assign wr_next   = wr_q + 1'b1;
	assign head      = entry_q[rd_q];
	assign not_empty = count_q != '0;
	// Two free slots are kept so that any request can be taken at once.
	assign full      = count_q > mas_pkg::QUEUE_CW'(mas_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_q] <= push.item[0];
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_next] <= push.item[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + mas_pkg::QUEUE_AW'(push.cnt);
			rd_q    <= rd_q + mas_pkg::QUEUE_AW'(pop);
			count_q <= count_q + mas_pkg::QUEUE_CW'(push.cnt) - mas_pkg::QUEUE_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mas_back.sv =====
// Output register that drains the result queue onto the output channel.
`timescale 1ns / 1ps
`default_nettype none

module mas_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mas_pkg::res_t   head,
	input  wire logic            not_empty,
	output logic                 pop,
	input  wire logic            out_stall,
	output logic                 out_valid,
	output mas_pkg::res_t        out_res
);

	logic          valid_q;
	mas_pkg::res_t res_q;

	assign pop       = not_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/macro_argument_splitter.sv =====
// Top level of the macro argument splitter: scanner, result queue and output stage.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    in_char, end_of_input, expected_params
// output    out        out_valid / out_stall  out_char, item_kind, error_code,
//                                             param_total, newline_seen, last_of_run
// config    in         cfg_we                 cfg_wdata (match_all_brackets)
//
// Unless stalled, the scanner takes one character request per cycle and turns it
// into zero, one or two results in that same cycle; the bracket stack is read and
// written in one step. The output stage sends one result per unstalled cycle, so
// sustained rate is one request per cycle while each request gives at most one
// result, and a two-result request lowers it. A four-entry result queue parts the
// sides: in_stall rises only with fewer than two slots free. Reset clears all scan
// state and sets bracket matching to all three kinds; there is no clearing pass.

module macro_argument_splitter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_char,
	input  wire logic        end_of_input,
	input  wire logic [5:0]  expected_params,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_char,
	output logic [1:0]       item_kind,
	output logic [2:0]       error_code,
	output logic [5:0]       param_total,
	output logic             newline_seen,
	output logic             last_of_run,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata
);

	logic              match_all_q;
	logic              accept;
	logic              full;
	logic              not_empty;
	logic              pop;
	mas_pkg::push_t    push;
	mas_pkg::res_t     head;
	mas_pkg::res_t     out_res;

	// Write the bracket mode register only while no request is in flight; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_all_q <= 1'b1;
		end else if (cfg_we) begin
			match_all_q <= cfg_wdata;
		end
	end

	// Stall depends only on queue occupancy, never on in_valid.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	mas_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_char         (in_char),
		.end_of_input    (end_of_input),
		.expected_params (expected_params),
		.match_all       (match_all_q),
		.push            (push)
	);

	mas_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	mas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign out_char     = out_res.ch;
	assign item_kind    = out_res.kind;
	assign error_code   = out_res.err;
	assign param_total  = out_res.total;
	assign newline_seen = out_res.newline;
	assign last_of_run  = out_res.last;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the macro argument splitter with a built-in scan predictor.
`timescale 1ns / 1ps

module tb;

	import mas_pkg::*;

	// The run is stopped here at the latest; a correct run needs far fewer cycles.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Cycles allowed after the last result before the block counts as idle. Requests
	// that give no result (comment text, a pending slash) may still be in the scanner.
	localparam int SETTLE_CYCLES = 16;

	// Scanner modes and bracket kinds as the predictor tracks them.
	typedef enum logic [2:0] {
		SC_NORMAL,
		SC_SLASH,
		SC_COMMENT,
		SC_STAR,
		SC_STRING,
		SC_ESCAPE
	} scan_t;

	typedef enum logic [1:0] {
		BR_PAREN,
		BR_BRACE,
		BR_SQUARE
	} bracket_t;

	// One character request as the sender presents it.
	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		logic [5:0] formals;
	} request_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_char = 8'h00;
	logic       end_of_input = 1'b0;
	logic [5:0] expected_params = 6'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic [1:0] item_kind;
	logic [2:0] error_code;
	logic [5:0] param_total;
	logic       newline_seen;
	logic       last_of_run;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;

	macro_argument_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_char(in_char),
		.end_of_input(end_of_input),
		.expected_params(expected_params),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.item_kind(item_kind),
		.error_code(error_code),
		.param_total(param_total),
		.newline_seen(newline_seen),
		.last_of_run(last_of_run),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be sent, and the results the scanner owes us, oldest first.
	request_t requests_to_send[$];
	res_t     results_due[$];
	res_t     step_out[$];

	int          failures = 0;
	int          cycles_run = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	logic [5:0]  gen_formals = 6'd0;

	// Predictor state. It mirrors the block's state right after reset.
	logic       brackets_all = 1'b1;
	bracket_t   open_kind [MAX_NEST];
	int         nest_level = 0;
	scan_t      scan_state = SC_NORMAL;
	logic       quote_dq = 1'b0;
	int         arg_index = 0;
	logic       saw_nonblank = 1'b0;
	int         bytes_taken = 0;
	logic       step_nl = 1'b0;
	logic [5:0] step_formals = 6'd0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Records one result of the current request. A request never gives more than two.
	function automatic void add_result(kind_t k, logic [7:0] c, err_t e, logic [5:0] t);
		res_t r;
		if (step_out.size() >= 2)
			return;
		r.ch = c;
		r.kind = k;
		r.err = e;
		r.total = t;
		r.newline = step_nl;
		r.last = 1'b0;
		step_out.push_back(r);
	endfunction

	// Ends the call. A blank lone argument counts as no argument at all. Without an
	// earlier error a full buffer still gives an overflow, and only otherwise is the
	// argument count compared with the number of formals.
	function automatic void close_call(err_t e);
		logic [5:0] total;
		total = 6'(arg_index + 1);
		if (arg_index == 0 && !saw_nonblank)
			total = 6'd0;
		if (e == ERR_NONE) begin
			if (bytes_taken >= BUFFER_BYTES)
				e = ERR_OVERFLOW;
			else if (total != step_formals)
				e = ERR_MISMATCH;
		end
		add_result(KIND_CALL, 8'h00, e, total);
		nest_level = 0;
		scan_state = SC_NORMAL;
		quote_dq = 1'b0;
		arg_index = 0;
		saw_nonblank = 1'b0;
		bytes_taken = 0;
	endfunction

	// Copies one byte into the argument buffer; returns 1 when the buffer was full and
	// the call was ended instead.
	function automatic logic copy_byte(logic [7:0] c);
		if (bytes_taken >= BUFFER_BYTES) begin
			close_call(ERR_OVERFLOW);
			return 1'b1;
		end
		bytes_taken++;
		if (arg_index == 0 && !(c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR}))
			saw_nonblank = 1'b1;
		add_result(KIND_CHAR, c, ERR_NONE, 6'd0);
		return 1'b0;
	endfunction

	function automatic logic [7:0] closer_for(bracket_t k);
		case (k)
			BR_BRACE: return CH_RBRACE;
			BR_SQUARE: return CH_RSQUARE;
			default: return CH_RPAREN;
		endcase
	endfunction

	// Handles a character outside strings and comments.
	function automatic void scan_plain(logic [7:0] c);
		logic [7:0] top_close;
		bracket_t   kind;
		logic       opener;
		top_close = CH_RPAREN;
		kind = BR_PAREN;
		opener = 1'b1;
		if (nest_level > 0)
			top_close = closer_for(open_kind[nest_level - 1]);
		// The closer of the innermost bracket, or the call's own close at the top.
		if (c == top_close) begin
			if (nest_level == 0) begin
				close_call(ERR_NONE);
				return;
			end
			if (!copy_byte(c))
				nest_level--;
			return;
		end
		// Any other closer is dropped with a notice.
		if (c == CH_RPAREN || (brackets_all && (c == CH_RBRACE || c == CH_RSQUARE))) begin
			add_result(KIND_NOTE, 8'h00, ERR_UNBALANCED, 6'd0);
			return;
		end
		if (c == CH_LPAREN)
			kind = BR_PAREN;
		else if (brackets_all && c == CH_LBRACE)
			kind = BR_BRACE;
		else if (brackets_all && c == CH_LSQUARE)
			kind = BR_SQUARE;
		else
			opener = 1'b0;
		if (opener) begin
			if (nest_level >= MAX_NEST) begin
				close_call(ERR_NESTING);
				return;
			end
			if (!copy_byte(c)) begin
				open_kind[nest_level] = kind;
				nest_level++;
			end
			return;
		end
		case (c)
			CH_LF: void'(copy_byte(CH_SPACE));
			CH_SLASH: scan_state = SC_SLASH;
			CH_COMMA: begin
				if (nest_level > 0)
					void'(copy_byte(c));
				else if (arg_index + 1 >= MAX_PARAMS)
					close_call(ERR_TOO_MANY);
				else if (bytes_taken >= BUFFER_BYTES)
					close_call(ERR_OVERFLOW);
				else begin
					bytes_taken++;
					arg_index++;
					add_result(KIND_PARAM, 8'h00, ERR_NONE, 6'd0);
				end
			end
			CH_DQUOTE, CH_SQUOTE: begin
				if (!copy_byte(c)) begin
					scan_state = SC_STRING;
					quote_dq = (c == CH_DQUOTE);
				end
			end
			default: void'(copy_byte(c));
		endcase
	endfunction

	// Works out the results of one accepted request and queues them as due.
	function automatic void scan_request(logic [7:0] c, logic eoi, logic [5:0] formals);
		logic [7:0] quote;
		res_t       r;
		step_out = {};
		step_formals = formals;
		step_nl = !eoi && c == CH_LF;
		if (eoi) begin
			// End of source: a held slash is text after all, then the call is cut off.
			if (scan_state == SC_SLASH) begin
				scan_state = SC_NORMAL;
				if (!copy_byte(CH_SLASH))
					close_call(ERR_UNTERMINATED);
			end else begin
				close_call(ERR_UNTERMINATED);
			end
		end else begin
			case (scan_state)
				SC_SLASH: begin
					if (c == CH_STAR) begin
						scan_state = SC_COMMENT;
					end else begin
						scan_state = SC_NORMAL;
						if (!copy_byte(CH_SLASH))
							scan_plain(c);
					end
				end
				SC_COMMENT: begin
					if (c == CH_STAR)
						scan_state = SC_STAR;
				end
				SC_STAR: begin
					if (c == CH_SLASH)
						scan_state = SC_NORMAL;
					else if (c != CH_STAR)
						scan_state = SC_COMMENT;
				end
				SC_STRING: begin
					quote = quote_dq ? CH_DQUOTE : CH_SQUOTE;
					if (c == quote) begin
						if (!copy_byte(c))
							scan_state = SC_NORMAL;
					end else if (c == CH_BSLASH) begin
						if (!copy_byte(c))
							scan_state = SC_ESCAPE;
					end else if (c == CH_LF) begin
						// A newline closes the string with a flagged quote and then
						// drops one bracket level, or the whole call at the top.
						if (!copy_byte(quote)) begin
							r = step_out.pop_back();
							r.err = ERR_NL_STRING;
							step_out.push_back(r);
							scan_state = SC_NORMAL;
							if (nest_level > 0) begin
								nest_level--;
								add_result(KIND_NOTE, 8'h00, ERR_UNTERMINATED, 6'd0);
							end else begin
								close_call(ERR_UNTERMINATED);
							end
						end
					end else begin
						void'(copy_byte(c));
					end
				end
				SC_ESCAPE: begin
					if (!copy_byte(c))
						scan_state = SC_STRING;
				end
				default: begin
					scan_state = SC_NORMAL;
					scan_plain(c);
				end
			endcase
		end
		if (step_out.size() != 0) begin
			r = step_out.pop_back();
			r.last = 1'b1;
			step_out.push_back(r);
		end
		foreach (step_out[i])
			results_due.push_back(step_out[i]);
	endfunction

	// ------------------------------------------------------------------
	// Source text generation
	// ------------------------------------------------------------------

	function automatic void queue_char(logic [7:0] c, logic eoi = 1'b0);
		request_t r;
		r.ch = eoi ? 8'($urandom_range(0, 255)) : c;
		r.eoi = eoi;
		r.formals = gen_formals;
		requests_to_send.push_back(r);
	endfunction

	// Any byte that has no meaning to the scanner.
	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LSQUARE, CH_RSQUARE,
				CH_COMMA, CH_SLASH, CH_STAR, CH_BSLASH, CH_LF, CH_DQUOTE, CH_SQUOTE})
			c = 8'h61 + {4'h0, c[3:0]};
		return c;
	endfunction

	function automatic logic [7:0] letter();
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(0, 4))
			0: return CH_TAB;
			1: return CH_VT;
			2: return CH_FF;
			3: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	// A well-formed string with escapes; an escape may hide a quote or a newline.
	function automatic void add_string();
		logic [7:0] q;
		logic [7:0] c;
		q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
		queue_char(q);
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 4) == 0) begin
				queue_char(CH_BSLASH);
				queue_char(8'($urandom_range(0, 255)));
			end else begin
				c = 8'($urandom_range(0, 255));
				if (c == q || c == CH_BSLASH || c == CH_LF)
					c = CH_SPACE;
				queue_char(c);
			end
		end
		queue_char(q);
	endfunction

	// A block comment; stars and newlines inside it give no result.
	function automatic void add_comment();
		logic [7:0] c;
		queue_char(CH_SLASH);
		queue_char(CH_STAR);
		repeat ($urandom_range(0, 4)) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_SLASH)
				c = CH_LF;
			queue_char(c);
		end
		queue_char(CH_STAR);
		queue_char(CH_SLASH);
	endfunction

	// A few tokens of argument text at the current bracket level.
	function automatic void add_filler();
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 6))
				0, 1: queue_char(plain_byte());
				2: add_string();
				3: add_comment();
				4: queue_char(CH_LF);
				5: begin
					// A lone slash that turns out not to open a comment.
					queue_char(CH_SLASH);
					queue_char(plain_byte());
				end
				default: queue_char(blank_byte());
			endcase
		end
	endfunction

	// Nested brackets of mixed kinds, with inner commas that must not split.
	function automatic void add_group();
		logic [7:0] closers [4];
		int         levels;
		levels = $urandom_range(1, 4);
		for (int i = 0; i < levels; i++) begin
			case ($urandom_range(0, 2))
				0: begin
					queue_char(CH_LPAREN);
					closers[i] = CH_RPAREN;
				end
				1: begin
					queue_char(CH_LBRACE);
					closers[i] = CH_RBRACE;
				end
				default: begin
					queue_char(CH_LSQUARE);
					closers[i] = CH_RSQUARE;
				end
			endcase
			add_filler();
		end
		for (int i = levels - 1; i >= 0; i--) begin
			if ($urandom_range(0, 2) == 0) begin
				queue_char(CH_COMMA);
				add_filler();
			end
			queue_char(closers[i]);
		end
	endfunction

	// Every argument starts with a letter, so it is never blank.
	function automatic void add_argument();
		queue_char(letter());
		add_filler();
		if ($urandom_range(0, 2) == 0)
			add_group();
		add_filler();
	endfunction

	// One macro call: mostly well formed, sometimes broken in a chosen way.
	function automatic void add_call();
		int n;
		int variant;
		int cnt;
		variant = $urandom_range(0, 19);
		n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
		gen_formals = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 32)) : 6'(n);
		case (variant)
			16: begin
				// Nesting at the limit, or one opener past it.
				gen_formals = 6'd1;
				queue_char(letter());
				if ($urandom_range(0, 1)) begin
					repeat (MAX_NEST + 1) queue_char(CH_LPAREN);
				end else begin
					repeat (MAX_NEST) queue_char(CH_LPAREN);
					queue_char(letter());
					repeat (MAX_NEST + 1) queue_char(CH_RPAREN);
				end
				return;
			end
			17: begin
				// Exactly the most arguments allowed, or one too many.
				cnt = $urandom_range(0, 1) ? MAX_PARAMS : MAX_PARAMS - 1;
				gen_formals = 6'(MAX_PARAMS);
				queue_char(letter());
				repeat (cnt) begin
					queue_char(CH_COMMA);
					queue_char(letter());
				end
				queue_char(CH_RPAREN);
				return;
			end
			default: ;
		endcase
		if (n == 0) begin
			repeat ($urandom_range(0, 2)) queue_char(blank_byte());
		end
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				queue_char(CH_COMMA);
			add_argument();
		end
		case (variant)
			13: queue_char(8'h00, 1'b1);
			14: begin
				// Stray closers, inside a square bracket and at the top.
				queue_char(CH_LSQUARE);
				queue_char(CH_RPAREN);
				queue_char(plain_byte());
				queue_char(CH_RSQUARE);
				queue_char(CH_RBRACE);
				queue_char(CH_RPAREN);
			end
			15: begin
				// A string cut by a newline, inside a bracket or at the top.
				if ($urandom_range(0, 1))
					queue_char(CH_LPAREN);
				queue_char($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
				queue_char(plain_byte());
				queue_char(CH_LF);
				queue_char(CH_RPAREN);
			end
			18: begin
				// A slash still held when the call closes or the source ends.
				queue_char(CH_SLASH);
				if ($urandom_range(0, 1))
					queue_char(8'h00, 1'b1);
				else
					queue_char(CH_RPAREN);
			end
			19: begin
				repeat ($urandom_range(1, 6)) queue_char(8'($urandom_range(0, 255)));
				queue_char(CH_RPAREN);
			end
			default: queue_char(CH_RPAREN);
		endcase
	endfunction

	// A call that fills the argument buffer exactly, then one more request.
	function automatic void add_long_call(logic [7:0] tail);
		gen_formals = 6'($urandom_range(0, 32));
		for (int i = 0; i < BUFFER_BYTES; i++)
			queue_char((i % 997 == 500) ? CH_COMMA : plain_byte());
		queue_char(tail);
	endfunction

	// Mostly calls, with some stray bytes and early ends of source between them.
	function automatic void add_random(int count);
		int goal;
		goal = requests_to_send.size() + count;
		while (requests_to_send.size() < goal) begin
			case ($urandom_range(0, 19))
				0: begin
					gen_formals = 6'($urandom_range(0, 32));
					queue_char(8'($urandom_range(0, 255)));
				end
				1: begin
					gen_formals = 6'($urandom_range(0, 32));
					queue_char(8'h00, 1'b1);
				end
				default: add_call();
			endcase
		end
	endfunction

	// The short directed opening. The scanner is fresh out of reset here.
	function automatic void add_directed();
		// A call with only a blank argument has zero arguments.
		gen_formals = 6'd0;
		queue_char(CH_SPACE);
		queue_char(CH_RPAREN);
		// Two arguments, the second with the extreme byte value 0xFF.
		gen_formals = 6'd2;
		queue_char(8'h78);
		queue_char(CH_COMMA);
		queue_char(8'hFF);
		queue_char(CH_RPAREN);
		// Argument count differs from the formal count.
		gen_formals = 6'd32;
		queue_char(8'h00);
		queue_char(CH_RPAREN);
		// A newline inside a string at the top level ends the call.
		gen_formals = 6'd1;
		queue_char(CH_SQUOTE);
		queue_char(8'h61);
		queue_char(CH_LF);
		// A comment holding a newline and a star vanishes; the call stays empty.
		gen_formals = 6'd0;
		queue_char(CH_SLASH);
		queue_char(CH_STAR);
		queue_char(CH_LF);
		queue_char(CH_STAR);
		queue_char(CH_SLASH);
		queue_char(CH_RPAREN);
		// An unbalanced brace is dropped with a notice.
		gen_formals = 6'd1;
		queue_char(CH_RBRACE);
		queue_char(8'h7A);
		queue_char(CH_RPAREN);
		// End of source with a slash held, then right after a newline.
		queue_char(CH_SLASH);
		queue_char(8'h00, 1'b1);
		queue_char(CH_LF);
		queue_char(8'h00, 1'b1);
	endfunction

	// ------------------------------------------------------------------
	// Driver, monitor and watchdog
	// ------------------------------------------------------------------

	// The sender. A request moves at an edge where in_valid is high and in_stall low;
	// that is where it enters the predictor. A held request never changes, and the
	// choice to idle does not look at in_stall.
	always @(posedge clk) begin : driver
		request_t req;
		if (in_valid && !in_stall)
			scan_request(in_char, end_of_input, expected_params);
		if (!in_valid || !in_stall) begin
			if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				req = requests_to_send.pop_front();
				in_valid <= 1'b1;
				in_char <= req.ch;
				end_of_input <= req.eoi;
				expected_params <= req.formals;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			failures++;
		end
	endfunction

	// The receiver. Each accepted result is checked against the oldest one due.
	always @(posedge clk) begin : monitor
		res_t want;
		if (out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d char %0d",
					$time, item_kind, out_char);
				failures++;
			end else begin
				want = results_due.pop_front();
				check_field("out_char", want.ch, out_char);
				check_field("item_kind", 8'(want.kind), 8'(item_kind));
				check_field("error_code", 8'(want.err), 8'(error_code));
				check_field("param_total", 8'(want.total), 8'(param_total));
				check_field("newline_seen", 8'(want.newline), 8'(newline_seen));
				check_field("last_of_run", 8'(want.last), 8'(last_of_run));
			end
		end
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	always @(posedge clk) begin : watchdog
		cycles_run <= cycles_run + 1;
		if (cycles_run == CYCLE_LIMIT) begin
			$display("[macro_argument_splitter] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Phases
	// ------------------------------------------------------------------

	// Waits until every request is sent and every result is in, then lets the
	// scanner settle so that requests without a result are surely done.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (requests_to_send.size() != 0 || in_valid || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the bracket matching mode; only called while the block is idle.
	task automatic load_bracket_mode(logic all_kinds);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= all_kinds;
		@(posedge clk);
		cfg_we <= 1'b0;
		brackets_all = all_kinds;
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset mode (all bracket kinds), no idling on either side. After the directed
		// part, three calls fill the buffer exactly: the close, a further character and
		// a top-level comma each find it full.
		add_directed();
		add_long_call(CH_RPAREN);
		add_long_call(8'h71);
		add_long_call(CH_COMMA);
		add_random(300);
		wait_drained();

		// Parentheses only, sender mostly idle.
		sender_idle_pct = 78;
		receiver_stall_pct = 0;
		load_bracket_mode(1'b0);
		add_random(330);
		wait_drained();

		// All bracket kinds, receiver mostly stalled. Halfway through, the sender
		// holds back until every result has arrived.
		sender_idle_pct = 0;
		receiver_stall_pct = 78;
		load_bracket_mode(1'b1);
		add_random(160);
		wait_drained();
		add_random(170);
		wait_drained();

		// Parentheses only, both sides idling now and then.
		sender_idle_pct = 28;
		receiver_stall_pct = 28;
		load_bracket_mode(1'b0);
		add_random(330);
		wait_drained();

		// All bracket kinds again at full rate.
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		load_bracket_mode(1'b1);
		add_random(330);
		wait_drained();

		if (failures == 0)
			$display("[macro_argument_splitter] OK");
		else
			$display("[macro_argument_splitter] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mas_pkg.sv
rtl/core/mas_front.sv
rtl/core/mas_queue.sv
rtl/core/mas_back.sv
rtl/core/macro_argument_splitter.sv
tb/sv/tb.sv
